// ===== src/bpc_pkg.sv =====
// Shared types, constants and helpers for the pressure compensation pipeline.
package bpc_pkg;

   // register indexes on the configuration port
   typedef enum logic [1:0] {
      CSR_CAL_A        = 2'd0,
      CSR_CAL_B        = 2'd1,
      CSR_CAL_C        = 2'd2,
      CSR_OVERSAMPLING = 2'd3
   } csr_index_type;

   localparam int          DIV_W       = 32;
   localparam logic [31:0] B6_OFFSET   = 32'd4000;
   localparam logic [31:0] X3_OFFSET   = 32'd32768;
   localparam logic [31:0] B7_BASE     = 32'd50000;
   localparam logic [31:0] P_SQ_COEF   = 32'd3038;
   localparam logic [31:0] P_LIN_COEF  = 32'd7357;
   localparam logic [31:0] P_BIAS      = 32'd3791;
   localparam logic [31:0] T_ROUND     = 32'd8;

   // sideband carried alongside the temperature division
   typedef struct packed {
      logic [31:0] x1;
      logic [23:0] up;
      logic        err;
      logic        neg;
   } div1_side_type;

   // sideband carried alongside the pressure division
   typedef struct packed {
      logic [31:0] t;
      logic        err;
      logic        high;
   } div2_side_type;

   // arithmetic right shift of a 32-bit two's complement word
   function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
      asr = 32'($signed(v) >>> n);
   endfunction

   // 50000 scaled down by the oversampling setting
   function automatic logic [31:0] b7_scale(input logic [1:0] oss);
      b7_scale = B7_BASE >> oss;
   endfunction

   // sign-extend a 16-bit calibration field
   function automatic logic [31:0] sx16(input logic [15:0] v);
      sx16 = {{16{v[15]}}, v};
   endfunction

endpackage

// ===== src/bpc_div.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage.
module bpc_div import bpc_pkg::*; #(
   parameter int DW = 32,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [DW-1:0] in_dividend,
   input  logic [DW-1:0] in_divisor,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [DW-1:0] out_quotient,
   output logic [SW-1:0] out_side
);

   logic [DW-1:0] valid_ff;
   logic [DW-1:0] quo_ff  [DW];
   logic [DW-1:0] rem_ff  [DW];
   logic [DW-1:0] dsr_ff  [DW];
   logic [SW-1:0] side_ff [DW];

   for (genvar g = 0; g < DW; g++) begin : g_stage
      logic          v_prev;
      logic [DW-1:0] quo_prev;
      logic [DW-1:0] rem_prev;
      logic [DW-1:0] dsr_prev;
      logic [SW-1:0] side_prev;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          fit;
      logic [DW-1:0] rem_in;
      logic [DW-1:0] quo_in;

      if (g == 0) begin : g_first
         assign v_prev    = in_valid;
         assign quo_prev  = in_dividend;
         assign rem_prev  = '0;
         assign dsr_prev  = in_divisor;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = valid_ff[g-1];
         assign quo_prev  = quo_ff[g-1];
         assign rem_prev  = rem_ff[g-1];
         assign dsr_prev  = dsr_ff[g-1];
         assign side_prev = side_ff[g-1];
      end

      // shift in the next dividend bit and try a subtract
      assign trial  = {rem_prev, quo_prev[DW-1]};
      assign diff   = trial - {1'b0, dsr_prev};
      assign fit    = trial >= {1'b0, dsr_prev};
      assign rem_in = fit ? diff[DW-1:0] : trial[DW-1:0];
      assign quo_in = {quo_prev[DW-2:0], fit};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         quo_ff[g]  <= quo_in;
         rem_ff[g]  <= rem_in;
         dsr_ff[g]  <= dsr_prev;
         side_ff[g] <= side_prev;
      end
   end

   assign out_valid    = valid_ff[DW-1];
   assign out_quotient = quo_ff[DW-1];
   assign out_side     = side_ff[DW-1];

endmodule

// ===== src/barometric_pressure_compensation.sv =====
// Top level: temperature and pressure compensation pipeline.
//
// Requests enter on start with req_raw_temperature and req_raw_pressure_bytes.
// busy is always low: the pipeline takes one request in every clock cycle.
// Each request yields one response, shown on the rsp_ ports for one cycle
// with rsp_valid high; the sustained rate is one request per cycle.
// The pipeline holds the two 32-stage dividers (one quotient bit each
// stage) plus fourteen arithmetic stages.
// Calibration words and the oversampling setting are written through the
// csr_ port (index 0..3) and must be written while no request is in flight.
// rsp_divide_error is set when X1+MD or B4 is zero; both values are then 0.
// Responses cannot be held off; results are in order, none dropped.
// Reset clears all valid bits and the calibration registers to zero;
// no response appears in the cycle after reset.
module barometric_pressure_compensation import bpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_raw_temperature,
   input  logic [23:0] req_raw_pressure_bytes,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data,
   output logic        rsp_valid,
   output logic signed [31:0] rsp_temperature_tenths,
   output logic signed [31:0] rsp_pressure_pa,
   output logic        rsp_divide_error
);

   // configuration registers
   logic [63:0] cal_a_ff;
   logic [63:0] cal_b_ff;
   logic [31:0] cal_c_ff;
   logic [1:0]  oss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_a_ff <= '0;
         cal_b_ff <= '0;
         cal_c_ff <= '0;
         oss_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CAL_A:        cal_a_ff <= csr_write_data;
            CSR_CAL_B:        cal_b_ff <= csr_write_data;
            CSR_CAL_C:        cal_c_ff <= csr_write_data[31:0];
            CSR_OVERSAMPLING: oss_ff   <= csr_write_data[1:0];
            default:          ;
         endcase
      end
   end

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = sx16(cal_a_ff[63:48]);
   assign ac2 = sx16(cal_a_ff[47:32]);
   assign ac3 = sx16(cal_a_ff[31:16]);
   assign ac4 = {16'd0, cal_a_ff[15:0]};
   assign ac5 = {16'd0, cal_b_ff[63:48]};
   assign ac6 = {16'd0, cal_b_ff[47:32]};
   assign b1  = sx16(cal_b_ff[31:16]);
   assign b2  = sx16(cal_b_ff[15:0]);
   assign mc  = sx16(cal_c_ff[31:16]);
   assign md  = sx16(cal_c_ff[15:0]);

   assign busy = 1'b0;

   // valid bits of the arithmetic stages
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff;
   logic v10_ff, v11_ff, v12_ff, v13_ff;
   logic d1_valid, d2_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         {v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff} <= '0;
         {v7_ff, v8_ff, v9_ff, v10_ff, v11_ff, v12_ff, v13_ff} <= '0;
      end else begin
         v0_ff  <= start & ~busy;
         v1_ff  <= v0_ff;
         v2_ff  <= v1_ff;
         v3_ff  <= d1_valid;
         v4_ff  <= v3_ff;
         v5_ff  <= v4_ff;
         v6_ff  <= v5_ff;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= d2_valid;
         v11_ff <= v10_ff;
         v12_ff <= v11_ff;
         v13_ff <= v12_ff;
      end
   end

   // stage 0: capture request, apply oversampling shift
   logic [15:0] ut0_ff;
   logic [23:0] up0_ff;
   always_ff @(posedge clock) begin
      ut0_ff <= req_raw_temperature;
      up0_ff <= req_raw_pressure_bytes >> (4'd8 - {2'b00, oss_ff});
   end

   // stage 1: (UT - AC6) * AC5
   logic [31:0] p1_ff;
   logic [23:0] up1_ff;
   always_ff @(posedge clock) begin
      p1_ff  <= 32'(({16'd0, ut0_ff} - ac6) * ac5);
      up1_ff <= up0_ff;
   end

   // stage 2: X1 and the divisor X1 + MD
   logic [31:0] x1_2_ff, d2_ff;
   logic [23:0] up2_ff;
   logic [31:0] x1_2_in;
   assign x1_2_in = asr(p1_ff, 5'd15);
   always_ff @(posedge clock) begin
      x1_2_ff <= x1_2_in;
      d2_ff   <= x1_2_in + md;
      up2_ff  <= up1_ff;
   end

   // magnitudes and signs for the signed division MC*2048 / (X1+MD)
   logic [31:0]   num2, num_mag, den_mag;
   div1_side_type d1_side_in, d1_side_out;
   logic [31:0]   q1;
   assign num2    = mc << 11;
   assign num_mag = num2[31] ? (32'd0 - num2) : num2;
   assign den_mag = d2_ff[31] ? (32'd0 - d2_ff) : d2_ff;
   assign d1_side_in.x1  = x1_2_ff;
   assign d1_side_in.up  = up2_ff;
   assign d1_side_in.err = (d2_ff == 32'd0);
   assign d1_side_in.neg = num2[31] ^ d2_ff[31];

   bpc_div #(.DW(DIV_W), .SW($bits(div1_side_type))) u_div_temp (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (v2_ff),
      .in_dividend  (num_mag),
      .in_divisor   (den_mag),
      .in_side      (d1_side_in),
      .out_valid    (d1_valid),
      .out_quotient (q1),
      .out_side     (d1_side_out)
   );

   // stage 3: B5 = X1 + X2
   logic [31:0] b5_3_ff;
   logic [23:0] up3_ff;
   logic        err3_ff;
   always_ff @(posedge clock) begin
      b5_3_ff <= d1_side_out.x1 + (d1_side_out.neg ? (32'd0 - q1) : q1);
      up3_ff  <= d1_side_out.up;
      err3_ff <= d1_side_out.err;
   end

   // stage 4: temperature and B6
   logic [31:0] b6_4_ff, t4_ff;
   logic [23:0] up4_ff;
   logic        err4_ff;
   always_ff @(posedge clock) begin
      b6_4_ff <= b5_3_ff - B6_OFFSET;
      t4_ff   <= asr(b5_3_ff + T_ROUND, 5'd4);
      up4_ff  <= up3_ff;
      err4_ff <= err3_ff;
   end

   // stage 5: B6*B6, AC2*B6, AC3*B6
   logic [31:0] sqr5_ff, ac2m5_ff, ac3m5_ff, t5_ff;
   logic [23:0] up5_ff;
   logic        err5_ff;
   always_ff @(posedge clock) begin
      sqr5_ff  <= 32'(b6_4_ff * b6_4_ff);
      ac2m5_ff <= 32'(ac2 * b6_4_ff);
      ac3m5_ff <= 32'(ac3 * b6_4_ff);
      t5_ff    <= t4_ff;
      up5_ff   <= up4_ff;
      err5_ff  <= err4_ff;
   end

   // stage 6: B2 and B1 products of the squared term
   logic [31:0] pb2_6_ff, pb1_6_ff, x2a6_ff, x1c6_ff, t6_ff, sq6;
   logic [23:0] up6_ff;
   logic        err6_ff;
   assign sq6 = asr(sqr5_ff, 5'd12);
   always_ff @(posedge clock) begin
      pb2_6_ff <= 32'(b2 * sq6);
      pb1_6_ff <= 32'(b1 * sq6);
      x2a6_ff  <= asr(ac2m5_ff, 5'd11);
      x1c6_ff  <= asr(ac3m5_ff, 5'd13);
      t6_ff    <= t5_ff;
      up6_ff   <= up5_ff;
      err6_ff  <= err5_ff;
   end

   // stage 7: B3 and the B4 factor
   logic [31:0] x3a7, b3v7, x3b7;
   logic [31:0] b3_7_ff, x3b7_ff, t7_ff;
   logic [23:0] up7_ff;
   logic        err7_ff;
   assign x3a7 = asr(pb2_6_ff, 5'd11) + x2a6_ff;
   assign b3v7 = ((ac1 << 2) + x3a7) << oss_ff;
   assign x3b7 = asr(asr(pb1_6_ff, 5'd16) + x1c6_ff + 32'd2, 5'd2);
   always_ff @(posedge clock) begin
      // truncate toward zero when dividing by four
      b3_7_ff <= (b3v7 + 32'd2) + ((b3v7 + 32'd2) >= 32'h8000_0000 ? 32'd3 : 32'd0);
      x3b7_ff <= x3b7 + X3_OFFSET;
      t7_ff   <= t6_ff;
      up7_ff  <= up6_ff;
      err7_ff <= err6_ff;
   end

   // stage 8: AC4 product and UP - B3
   logic [31:0] b4p8_ff, diff8_ff, t8_ff;
   logic        err8_ff;
   always_ff @(posedge clock) begin
      b4p8_ff  <= 32'(ac4 * x3b7_ff);
      diff8_ff <= {8'd0, up7_ff} - asr(b3_7_ff, 5'd2);
      t8_ff    <= t7_ff;
      err8_ff  <= err7_ff;
   end

   // stage 9: B4 and B7
   logic [31:0] b4_9_ff, b7_9_ff, t9_ff;
   logic        err9_ff;
   always_ff @(posedge clock) begin
      b4_9_ff <= b4p8_ff >> 15;
      b7_9_ff <= 32'(diff8_ff * b7_scale(oss_ff));
      t9_ff   <= t8_ff;
      err9_ff <= err8_ff | (b4p8_ff[31:15] == 17'd0);
   end

   // pressure division B7 / B4
   div2_side_type d2_side_in, d2_side_out;
   logic [31:0]   q2, dvd2;
   assign dvd2            = b7_9_ff[31] ? b7_9_ff : (b7_9_ff << 1);
   assign d2_side_in.t    = t9_ff;
   assign d2_side_in.err  = err9_ff;
   assign d2_side_in.high = b7_9_ff[31];

   bpc_div #(.DW(DIV_W), .SW($bits(div2_side_type))) u_div_press (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (v9_ff),
      .in_dividend  (dvd2),
      .in_divisor   (b4_9_ff),
      .in_side      (d2_side_in),
      .out_valid    (d2_valid),
      .out_quotient (q2),
      .out_side     (d2_side_out)
   );

   // stage 10: raw pressure
   logic [31:0] p10_ff, t10_ff;
   logic        err10_ff;
   always_ff @(posedge clock) begin
      p10_ff   <= d2_side_out.high ? (q2 << 1) : q2;
      t10_ff   <= d2_side_out.t;
      err10_ff <= d2_side_out.err;
   end

   // stage 11: square of p/256 and the linear term
   logic [31:0] sqp11_ff, m7_11_ff, p11_ff, t11_ff, ps10;
   logic        err11_ff;
   assign ps10 = asr(p10_ff, 5'd8);
   always_ff @(posedge clock) begin
      sqp11_ff <= 32'(ps10 * ps10);
      m7_11_ff <= 32'(P_LIN_COEF * p10_ff);
      p11_ff   <= p10_ff;
      t11_ff   <= t10_ff;
      err11_ff <= err10_ff;
   end

   // stage 12: scale the square term and shift the negated linear term
   logic [31:0] m3_12_ff, x2_12_ff, p12_ff, t12_ff;
   logic        err12_ff;
   always_ff @(posedge clock) begin
      m3_12_ff <= 32'(sqp11_ff * P_SQ_COEF);
      x2_12_ff <= asr(32'd0 - m7_11_ff, 5'd16);
      p12_ff   <= p11_ff;
      t12_ff   <= t11_ff;
      err12_ff <= err11_ff;
   end

   // stage 13: final correction, force zero on a divide error
   logic [31:0] pf12, t13_ff, p13_ff;
   logic        err13_ff;
   assign pf12 = p12_ff + asr(asr(m3_12_ff, 5'd16) + x2_12_ff + P_BIAS, 5'd4);
   always_ff @(posedge clock) begin
      t13_ff   <= err12_ff ? 32'd0 : t12_ff;
      p13_ff   <= err12_ff ? 32'd0 : pf12;
      err13_ff <= err12_ff;
   end

   assign rsp_valid              = v13_ff;
   assign rsp_temperature_tenths = $signed(t13_ff);
   assign rsp_pressure_pa        = $signed(p13_ff);
   assign rsp_divide_error       = err13_ff;

   // an error response always carries zero values
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_error |->
         rsp_pressure_pa == 32'sd0 && rsp_temperature_tenths == 32'sd0)
      else $error("error response with nonzero values");

   // every accepted request is answered with rsp_valid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##78 rsp_valid)
      else $error("response missing at expected latency");

   // reset leaves no response in flight
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !v0_ff)
      else $error("response after reset");

endmodule
